FILE: rtl/cha_pkg.sv
// Shared widths, angle constants and the arctangent table for the compass heading pipeline.
package cha_pkg;

    localparam int VEC_W     = 27;
    localparam int ANG_W     = 26;
    localparam int IN_W      = 16;
    localparam int HEAD_W    = 15;
    localparam int TABLE_LEN = 24;

    localparam logic signed [ANG_W-1:0] DEG180_FIX = 26'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG360_FIX = 26'sd23592960;
    localparam logic signed [ANG_W-1:0] ROUND_HALF = 26'sd512;
    localparam logic [HEAD_W:0]         HEADING_FULL = 16'd23040;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [ANG_W-1:0] t_ang;

    // Arctangent of 2^-i in degrees, scaled by 2^16 and rounded to nearest.
    localparam t_ang ANGLE_STEP [TABLE_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

endpackage

FILE: rtl/compass_heading_atan2.sv
// A sample moves through the pre-rotation, CORDIC stage and heading output registers.
// One sample per cycle unless stalled; each micro-rotation has its own pipeline stage.
// When the output is stalled while it holds a heading, the whole pipeline holds in place.
// Reset is synchronous and active low; it clears only the valid bits of the pipeline.
// Top level of the vectoring CORDIC that turns magnetometer X and Y counts into a heading.
module compass_heading_atan2 #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [cha_pkg::IN_W-1:0] i_mag_x,
    input  logic signed [cha_pkg::IN_W-1:0] i_mag_y,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [cha_pkg::HEAD_W-1:0]  o_heading
);
    import cha_pkg::*;

    localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN :
                        ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);

    t_vec r_x [NS+1];
    t_vec r_y [NS+1];
    t_ang r_z [NS+1];
    logic r_vld  [NS+1];
    logic r_zero [NS+1];

    t_vec n_x [NS+1];
    t_vec n_y [NS+1];
    t_ang n_z [NS+1];

    logic              r_out_vld;
    logic [HEAD_W-1:0] r_heading;
    logic [HEAD_W-1:0] n_heading;
    logic              w_en;

    t_vec w_x_in;
    t_vec w_y_in;
    t_ang w_z_fold;
    logic [HEAD_W:0] w_h_raw;

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = r_out_vld && i_stall;
    assign o_valid = r_out_vld;
    assign o_heading = r_heading;

    assign w_x_in = {{(VEC_W-IN_W-8){i_mag_x[IN_W-1]}}, i_mag_x, 8'd0};
    assign w_y_in = {{(VEC_W-IN_W-8){i_mag_y[IN_W-1]}}, i_mag_y, 8'd0};

    always_comb begin
        if (w_x_in[VEC_W-1]) begin
            n_x[0] = -w_x_in;
            n_y[0] = -w_y_in;
            n_z[0] = DEG180_FIX;
        end else begin
            n_x[0] = w_x_in;
            n_y[0] = w_y_in;
            n_z[0] = '0;
        end
        for (int i = 0; i < NS; i++) begin
            if (!r_y[i][VEC_W-1]) begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_z[i] + ANGLE_STEP[i];
            end else begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_z[i] - ANGLE_STEP[i];
            end
        end
    end

    always_comb begin
        w_z_fold = r_z[NS] + (r_z[NS][ANG_W-1] ? DEG360_FIX : '0) + ROUND_HALF;
        w_h_raw  = w_z_fold[ANG_W-1:10];
        if (r_zero[NS]) begin
            n_heading = '0;
        end else if (w_h_raw >= HEADING_FULL) begin
            n_heading = HEAD_W'(w_h_raw - HEADING_FULL);
        end else begin
            n_heading = w_h_raw[HEAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NS; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int i = 0; i < NS; i++) begin
                r_vld[i+1] <= r_vld[i];
            end
            r_out_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero[0] <= (i_mag_x == '0) && (i_mag_y == '0);
            for (int i = 0; i <= NS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
            for (int i = 0; i < NS; i++) begin
                r_zero[i+1] <= r_zero[i];
            end
            r_heading <= n_heading;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_vld)
        else $error("stall raised with an empty output register");

    a_prerot_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> !r_x[0][VEC_W-1])
        else $error("pre-rotation left a negative x");

    a_last_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS] && !o_stall) |=> o_valid)
        else $error("last CORDIC stage lost its transaction");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_heading} < HEADING_FULL))
        else $error("heading out of range");

endmodule

FILE: sim/compass_heading_atan2_tb.sv
// Self-checking testbench for the pipelined CORDIC compass heading block.
module compass_heading_atan2_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cha_pkg::*;

    localparam int STAGES     = 16;
    localparam int DRAIN_WAIT = STAGES + 12;
    localparam int CYCLE_MAX  = 200000;
    localparam int HOLD_LEN   = 200;
    localparam int N_PHASE    = 90;

    localparam longint FIX_DEG180 = 180 * 65536;
    localparam longint FIX_DEG360 = 360 * 65536;
    localparam longint FULL_TURN  = 23040;

    localparam longint ATAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [IN_W-1:0]   i_mag_x = '0;
    logic signed [IN_W-1:0]   i_mag_y = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [HEAD_W-1:0]        o_heading;

    logic [HEAD_W-1:0] heading_due [$];
    int error_cnt      = 0;
    int cycle_cnt      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    compass_heading_atan2 #(
        .CORDIC_STAGES(STAGES)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_mag_x  (i_mag_x),
        .i_mag_y  (i_mag_y),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_heading(o_heading)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [HEAD_W-1:0] heading_of(input logic signed [IN_W-1:0] mx,
                                                     input logic signed [IN_W-1:0] my);
        longint vx;
        longint vy;
        longint acc;
        longint dx;
        longint dy;
        longint h;
        int     n;
        int     k;
        if (mx == 0 && my == 0) begin
            return '0;
        end
        n = (STAGES > 24) ? 24 : ((STAGES < 1) ? 1 : STAGES);
        vx = longint'(mx) * 256;
        vy = longint'(my) * 256;
        acc = 0;
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            acc = FIX_DEG180;
        end
        for (k = 0; k < n; k++) begin
            dx = vx >>> k;
            dy = vy >>> k;
            if (vy >= 0) begin
                vx = vx + dy;
                vy = vy - dx;
                acc = acc + ATAN_DEG[k];
            end else begin
                vx = vx - dy;
                vy = vy + dx;
                acc = acc - ATAN_DEG[k];
            end
        end
        if (acc < 0) begin
            acc = acc + FIX_DEG360;
        end
        h = (acc + 512) >>> 10;
        if (h >= FULL_TURN) begin
            h = h - FULL_TURN;
        end
        return h[HEAD_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            i_stall <= 1'b1;
            hold_left <= HOLD_LEN - 1;
            hold_served <= hold_served + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_heading
        logic [HEAD_W-1:0] want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                heading_due.push_back(heading_of(i_mag_x, i_mag_y));
            end
            if (o_valid && !i_stall) begin
                if (heading_due.size() == 0) begin
                    error_cnt = error_cnt + 1;
                    if (error_cnt <= 10) begin
                        $display("unexpected heading transaction: got %0d", o_heading);
                    end
                end else begin
                    want = heading_due.pop_front();
                    if (o_heading !== want) begin
                        error_cnt = error_cnt + 1;
                        if (error_cnt <= 10) begin
                            $display("heading mismatch: expected %0d, got %0d",
                                     want, o_heading);
                        end
                    end
                end
            end
        end
    end

    task automatic send_sample(input logic signed [IN_W-1:0] x,
                               input logic signed [IN_W-1:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mag_x <= x;
        i_mag_y <= y;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    function automatic logic signed [IN_W-1:0] rand_count(input int kind);
        logic signed [IN_W-1:0] v;
        case (kind)
            0: v = IN_W'($urandom);
            1: v = IN_W'(int'($urandom_range(8)) - 4);
            2: v = IN_W'(int'($urandom_range(512)) - 256);
            default: v = '0;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd0, 16'sd32767);
        send_sample(16'sd0, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd1);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd1, -16'sd1);
        send_sample(-16'sd1, 16'sd1);
        send_sample(16'sd32767, -16'sd1);
        send_sample(-16'sd32768, -16'sd1);
        send_sample(-16'sd32768, 16'sd1);
        send_sample(16'sd32767, 16'sd1);
        send_sample(-16'sd21846, 16'sd0);
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        int sel;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) begin
            sel = $urandom_range(9);
            if (sel <= 5) begin
                x = rand_count(0);
                y = rand_count(0);
            end else if (sel == 6) begin
                x = rand_count(1);
                y = rand_count(1);
            end else if (sel == 7) begin
                x = rand_count(2);
                y = rand_count(2);
            end else if (sel == 8) begin
                x = $urandom_range(1) ? rand_count(0) : '0;
                y = (x == 0) ? rand_count(0) : '0;
            end else begin
                x = rand_count(0);
                y = $urandom_range(1) ? x : -x;
            end
            send_sample(x, y);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = hold_requests + 1;
        test_random(60, 0, 0);
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (heading_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(N_PHASE, 0, 0);
        test_random(N_PHASE, 85, 0);
        test_random(N_PHASE, 0, 85);
        test_random(N_PHASE, 14, 14);
        test_backpressure();
        drain_pipeline();
        if (error_cnt == 0 && heading_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/cha_pkg.sv
rtl/compass_heading_atan2.sv
sim/compass_heading_atan2_tb.sv
